@@ sv/ptt_pkg.sv @@
// Shared types and constants for the page translation table.
package ptt_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int ENTRIES    = 64;
   localparam int ADDR_W     = 64;
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_LOOKUP_V = 2'd1,
      OP_LOOKUP_P = 2'd2,
      OP_RSVD     = 2'd3
   } opcode_type;

   localparam logic [2:0] ST_OK              = 3'd0;
   localparam logic [2:0] ST_MISS            = 3'd1;
   localparam logic [2:0] ST_VIRT_ZERO       = 3'd2;
   localparam logic [2:0] ST_PHYS_ZERO       = 3'd3;
   localparam logic [2:0] ST_VIRT_UNALIGNED  = 3'd4;
   localparam logic [2:0] ST_PHYS_UNALIGNED  = 3'd5;
   localparam logic [2:0] ST_REMOVED_OR_FULL = 3'd6;

   typedef struct packed {
      opcode_type         opcode;
      logic [ADDR_W-1:0]  virt_addr;
      logic [ADDR_W-1:0]  phys_addr;
      logic [7:0]         desc_type;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  result_addr;
      logic [2:0]         status;
      logic               table_full;
   } rsp_type;

   // Update command into one map: set writes key/value and marks valid,
   // clr drops the valid bit of the slot.
   typedef struct packed {
      logic               set;
      logic               clr;
      logic [IDX_W-1:0]   idx;
      logic [PAGE_W-1:0]  key;
      logic [PAGE_W-1:0]  value;
   } ptt_wr_type;

   // Outcome of one full scan of a map.
   typedef struct packed {
      logic               done;
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic               free;
      logic [IDX_W-1:0]   free_idx;
      logic [PAGE_W-1:0]  hit_value;
   } ptt_scan_type;

endpackage

@@ sv/ptt_map.sv @@
// One page map: key/value memory, valid bits and a single-comparator scan.
module ptt_map (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 scan_go,
   input  logic [ptt_pkg::PAGE_W-1:0] scan_key,
   input  ptt_pkg::ptt_wr_type  wr,
   output ptt_pkg::ptt_scan_type scan
);
   import ptt_pkg::*;

   logic [PAGE_W-1:0] key_mem [ENTRIES];
   logic [PAGE_W-1:0] val_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic              busy_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              cmp_en_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [PAGE_W-1:0] key_ff;
   logic [PAGE_W-1:0] key_rd_ff;
   logic [PAGE_W-1:0] val_rd_ff;
   logic              done_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [PAGE_W-1:0] hit_val_ff;

   logic              match;
   logic              last_cmp;

   assign match    = valid_ff[cmp_idx_ff] && (key_rd_ff == key_ff);
   assign last_cmp = cmp_en_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.set) begin
         key_mem[wr.idx] <= wr.key;
         val_mem[wr.idx] <= wr.value;
      end
      key_rd_ff <= key_mem[rd_idx_ff];
      val_rd_ff <= val_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.set) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.clr) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   // scan sequencer: read address leads compare, which uses the address registered the cycle before
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rd_idx_ff <= '0;
         cmp_en_ff <= 1'b0;
         done_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         cmp_en_ff <= busy_ff;
         done_ff   <= last_cmp;
         if (scan_go) begin
            busy_ff   <= 1'b1;
            rd_idx_ff <= '0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
         end else begin
            if (busy_ff) begin
               rd_idx_ff <= rd_idx_ff + IDX_W'(1);
               if (rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  busy_ff <= 1'b0;
               end
            end
            if (cmp_en_ff) begin
               if (match && !hit_ff) begin
                  hit_ff <= 1'b1;
               end
               if (!valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (scan_go) begin
         key_ff <= scan_key;
      end
      if (cmp_en_ff && match && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_val_ff <= val_rd_ff;
      end
      if (cmp_en_ff && !valid_ff[cmp_idx_ff] && !free_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   assign scan.done      = done_ff;
   assign scan.hit       = hit_ff;
   assign scan.hit_idx   = hit_idx_ff;
   assign scan.free      = free_ff;
   assign scan.free_idx  = free_idx_ff;
   assign scan.hit_value = hit_val_ff;

endmodule

@@ sv/page_translation_table.sv @@
// Top level of the bidirectional page translation table.
//
// Two page maps of ENTRIES slots each: forward (virtual page to physical page)
// and reverse (physical page to virtual page). A beat is taken when start is
// high and busy is low. An add whose operands fail a check (virtual zero,
// physical zero, virtual unaligned, physical unaligned, tested in that order)
// and the unused opcode answer at once: the response strobes on the cycle
// after the beat and busy never rises. Every other beat scans both maps side
// by side, one slot per cycle through a single key comparator per map behind
// a registered memory read, and the response strobes once the last slot of
// both maps has been compared and the done flag has been registered. busy is
// high from the cycle after the beat until the response cycle, and a new beat
// may be taken in the response cycle itself. rsp_valid is high for exactly one
// cycle per beat and the receiver cannot hold it off, so capture rsp_payload
// on that cycle. An add with a zero descriptor type removes both keys; an
// add that finds neither its key nor a free slot in one of the maps writes
// nothing, removes both keys and reports table_full. Lookups return the
// mapped page joined with the page offset, or zero with a miss status.
module page_translation_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ptt_pkg::req_type req_payload,
   output logic             rsp_valid,
   output ptt_pkg::rsp_type rsp_payload
);
   import ptt_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   logic      accept;
   logic      need_scan;
   rsp_type   early_rsp;
   rsp_type   final_rsp;

   logic [PAGE_SHIFT-1:0] virt_off;
   logic [PAGE_SHIFT-1:0] phys_off;
   logic [PAGE_W-1:0]     req_vpage;
   logic [PAGE_W-1:0]     req_ppage;

   ptt_scan_type fwd_scan;
   ptt_scan_type rev_scan;
   ptt_wr_type   fwd_wr;
   ptt_wr_type   rev_wr;

   assign accept    = start && !busy;
   assign busy      = (state_ff == S_SCAN);
   assign virt_off  = req_payload.virt_addr[PAGE_SHIFT-1:0];
   assign phys_off  = req_payload.phys_addr[PAGE_SHIFT-1:0];
   assign req_vpage = req_ff.virt_addr[ADDR_W-1:PAGE_SHIFT];
   assign req_ppage = req_ff.phys_addr[ADDR_W-1:PAGE_SHIFT];

   // decode: run the operand checks on the incoming beat
   always_comb begin
      need_scan             = 1'b0;
      early_rsp.result_addr = '0;
      early_rsp.status      = ST_MISS;
      early_rsp.table_full  = 1'b0;
      case (req_payload.opcode)
         OP_ADD: begin
            if (req_payload.virt_addr == '0) begin
               early_rsp.status = ST_VIRT_ZERO;
            end else if (req_payload.phys_addr == '0) begin
               early_rsp.status = ST_PHYS_ZERO;
            end else if (virt_off != '0) begin
               early_rsp.status = ST_VIRT_UNALIGNED;
            end else if (phys_off != '0) begin
               early_rsp.status = ST_PHYS_UNALIGNED;
            end else begin
               need_scan = 1'b1;
            end
         end
         OP_LOOKUP_V, OP_LOOKUP_P: begin
            need_scan = 1'b1;
         end
         default: begin
            need_scan = 1'b0;
         end
      endcase
   end

   // commit: once both scans are done, pick slots, update maps, form response
   always_comb begin
      fwd_wr                = '0;
      rev_wr                = '0;
      final_rsp.result_addr = '0;
      final_rsp.status      = ST_MISS;
      final_rsp.table_full  = 1'b0;
      fwd_wr.key            = req_vpage;
      fwd_wr.value          = req_ppage;
      rev_wr.key            = req_ppage;
      rev_wr.value          = req_vpage;
      fwd_wr.idx            = fwd_scan.hit_idx;
      rev_wr.idx            = rev_scan.hit_idx;
      case (req_ff.opcode)
         OP_ADD: begin
            if (req_ff.desc_type != '0 &&
                (fwd_scan.hit || fwd_scan.free) &&
                (rev_scan.hit || rev_scan.free)) begin
               fwd_wr.set       = state_ff == S_SCAN && fwd_scan.done;
               rev_wr.set       = state_ff == S_SCAN && fwd_scan.done;
               fwd_wr.idx       = fwd_scan.hit ? fwd_scan.hit_idx : fwd_scan.free_idx;
               rev_wr.idx       = rev_scan.hit ? rev_scan.hit_idx : rev_scan.free_idx;
               final_rsp.status = ST_OK;
            end else begin
               // remove, or clean up after a full table: drop both keys
               fwd_wr.clr           = state_ff == S_SCAN && fwd_scan.done && fwd_scan.hit;
               rev_wr.clr           = state_ff == S_SCAN && fwd_scan.done && rev_scan.hit;
               final_rsp.status     = ST_REMOVED_OR_FULL;
               final_rsp.table_full = (req_ff.desc_type != '0);
            end
         end
         OP_LOOKUP_V: begin
            if (fwd_scan.hit) begin
               final_rsp.result_addr = {fwd_scan.hit_value,
                                        req_ff.virt_addr[PAGE_SHIFT-1:0]};
               final_rsp.status      = ST_OK;
            end
         end
         OP_LOOKUP_P: begin
            if (rev_scan.hit) begin
               final_rsp.result_addr = {rev_scan.hit_value,
                                        req_ff.phys_addr[PAGE_SHIFT-1:0]};
               final_rsp.status      = ST_OK;
            end
         end
         default: begin
            final_rsp.status = ST_MISS;
         end
      endcase
   end

   ptt_map u_fwd_map (
      .clock    (clock),
      .reset    (reset),
      .scan_go  (accept && need_scan),
      .scan_key (req_payload.virt_addr[ADDR_W-1:PAGE_SHIFT]),
      .wr       (fwd_wr),
      .scan     (fwd_scan)
   );

   ptt_map u_rev_map (
      .clock    (clock),
      .reset    (reset),
      .scan_go  (accept && need_scan),
      .scan_key (req_payload.phys_addr[ADDR_W-1:PAGE_SHIFT]),
      .wr       (rev_wr),
      .scan     (rev_scan)
   );

   // hold the beat for the commit step
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (need_scan) begin
                     state_ff <= S_SCAN;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= early_rsp;
                  end
               end
            end
            S_SCAN: begin
               if (fwd_scan.done) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= final_rsp;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // both maps scan in lockstep
   a_scan_lockstep: assert property (@(posedge clock) disable iff (reset)
      fwd_scan.done == rev_scan.done)
      else $error("forward and reverse scans out of step");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still scanning");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.table_full |-> rsp_payload.status == ST_REMOVED_OR_FULL)
      else $error("table_full without removed-or-full status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.result_addr == '0)
      else $error("nonzero address on a failed beat");

endmodule
